// File: design/u2ga_pkg.sv
package u2ga_pkg;

  // Width of the number field on the input channel.
  localparam int unsigned VALUE_W = 64;

  // Default width of the number that is actually converted.
  localparam int unsigned VALUE_BITS_DEF = 64;

  // Decimal digits of the largest 64-bit number, and the digit store width.
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned BCD_BITS = NUM_DIGITS * 4;
  localparam int unsigned CNT_W = $clog2(NUM_DIGITS + 1);

  // Digits per comma group, and the group phase of the top digit.
  localparam logic [1:0] GRP_LAST_DEC = 2'(3 - 1);
  localparam logic [1:0] GRP_LAST_HEX = 2'(4 - 1);
  localparam logic [1:0] GRP_INIT_DEC = 2'((NUM_DIGITS - 1) % 3);
  localparam logic [1:0] GRP_INIT_HEX = 2'((NUM_DIGITS - 1) % 4);

  // Characters.
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_A = 8'h41;

  // Radix selector codes.
  localparam logic RADIX_DEC = 1'b0;
  localparam logic RADIX_HEX = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               action;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic dabble;
    logic shift;
    logic emit_digit;
    logic emit_comma;
    logic emit_last;
  } u2ga_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bits_done;
    logic top_zero;
    logic count_one;
    logic group_zero;
    logic out_free;
  } u2ga_sts_t;

  // ASCII character of one digit, uppercase for hex letters.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_A + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// File: design/u2ga_dp.sv
module u2ga_dp import u2ga_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  u2ga_cmd_t cmd,
  output u2ga_sts_t sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned BIT_CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] bin_r;
  logic [BCD_BITS-1:0]   bcd_r;
  logic [BIT_CNT_W-1:0]  bit_cnt_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [1:0]            grp_r;
  logic                  hex_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic [BCD_BITS-1:0] bcd_adj;
  logic [3:0]          top_digit;

  // Add three to every decimal digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  assign top_digit = bcd_r[BCD_BITS-1 -: 4];

  // Conversion registers: load, bit-serial double dabble, digit shift.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r <= in_data.value[VALUE_BITS-1:0];
      hex_r <= in_data.action;
      cnt_r <= CNT_W'(NUM_DIGITS);
      if (in_data.action == RADIX_HEX) begin
        bcd_r     <= {{(BCD_BITS-VALUE_BITS){1'b0}}, in_data.value[VALUE_BITS-1:0]};
        bit_cnt_r <= '0;
        grp_r     <= GRP_INIT_HEX;
      end else begin
        bcd_r     <= '0;
        bit_cnt_r <= BIT_CNT_W'(VALUE_BITS);
        grp_r     <= GRP_INIT_DEC;
      end
    end else if (cmd.dabble) begin
      bcd_r     <= {bcd_adj[BCD_BITS-2:0], bin_r[VALUE_BITS-1]};
      bin_r     <= bin_r << 1;
      bit_cnt_r <= bit_cnt_r - 1'b1;
    end else if (cmd.shift) begin
      bcd_r <= bcd_r << 4;
      cnt_r <= cnt_r - 1'b1;
      if (grp_r == 2'd0) begin
        grp_r <= hex_r ? GRP_LAST_HEX : GRP_LAST_DEC;
      end else begin
        grp_r <= grp_r - 1'b1;
      end
    end
  end

  // Output register; a new beat may enter as the held one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_digit || cmd.emit_comma) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_digit) begin
      out_data_r.char_out <= digit_char(top_digit);
      out_data_r.last     <= cmd.emit_last;
    end else if (cmd.emit_comma) begin
      out_data_r.char_out <= CHAR_COMMA;
      out_data_r.last     <= 1'b0;
    end
  end

  assign sts.bits_done  = (bit_cnt_r == '0);
  assign sts.top_zero   = (top_digit == 4'd0);
  assign sts.count_one  = (cnt_r == CNT_W'(1));
  assign sts.group_zero = (grp_r == 2'd0);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The digit counter never runs below one digit.
  a_shift_keeps_digit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> cnt_r > CNT_W'(1))
    else $error("digit shift with only one digit left");

  // A comma is never flagged as the final character.
  a_comma_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_comma |=> !out_data_r.last)
    else $error("comma carries the last flag");

endmodule

// File: design/u2ga_ctrl.sv
module u2ga_ctrl import u2ga_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  u2ga_sts_t sts,
  output u2ga_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_DIGIT,
    ST_COMMA
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts.bits_done) begin
          state_nxt = ST_SCAN;
        end else begin
          cmd.dabble = 1'b1;
        end
      end
      ST_SCAN: begin
        // Drop leading zeros, keeping at least one digit.
        if (sts.top_zero && !sts.count_one) begin
          cmd.shift = 1'b1;
        end else begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          cmd.emit_last  = sts.count_one;
          if (sts.count_one) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.shift = 1'b1;
            if (sts.group_zero) begin
              state_nxt = ST_COMMA;
            end
          end
        end
      end
      ST_COMMA: begin
        if (sts.out_free) begin
          cmd.emit_comma = 1'b1;
          state_nxt      = ST_DIGIT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  // Characters are only produced when the output register can take them.
  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_digit || cmd.emit_comma) |-> sts.out_free)
    else $error("character emitted into a held output register");

  // The final digit ends the item.
  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_digit && cmd.emit_last) |=> state_r == ST_IDLE)
    else $error("controller busy after the final character");

endmodule

// File: design/unsigned_to_grouped_ascii_unit.sv
// Channel   Ports                          Beat
// input     in_valid, in_stall, in_data    value (64b) and radix selector
// output    out_valid, out_stall, out_data one character and last flag
//
// One item is converted at a time. A decimal item is loaded, converted by
// bit-serial double dabble over its VALUE_BITS bits, then its leading zeros are
// skipped, and then the characters are sent one by one (up to 26);
// hex items skip the double dabble and go straight from the load to the skip.
// The output register lets the next item enter while the final character waits.
// Reset is synchronous, active low, and clears the controller and output valid.
// Output stalls hold the current character and pause the controller.
module unsigned_to_grouped_ascii_unit import u2ga_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  u2ga_cmd_t cmd;
  u2ga_sts_t sts;

  u2ga_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  u2ga_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import u2ga_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 200;
  localparam int RANDOM_ITEMS = 290;
  localparam int HOLD_AFTER_CHARS = 300;
  localparam int HOLD_CYCLES = 600;
  localparam bit [63:0] VALUE_MASK = (VALUE_BITS_DEF >= 64) ? '1 :
                                     ((64'd1 << VALUE_BITS_DEF) - 64'd1);

  typedef struct packed {
    in_item_t beat;
    bit       drain_first;
  } number_job_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  number_job_t pending_numbers[$];
  out_item_t   expected_text[$];
  logic        in_took = 1'b0;
  int          error_count = 0;
  int          chars_seen = 0;
  int          cycles = 0;

  unsigned_to_grouped_ascii_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Print one line per mismatch and keep count.
  task automatic flag_error(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    error_count++;
  endtask

  // Queue the characters one number should produce, top digit first.
  function automatic void predict_text(in_item_t item);
    bit [63:0] num;
    bit [3:0]  digs[20];
    bit [63:0] radix;
    int        group;
    int        n;
    int        p;
    out_item_t ch;
    num = item.value & VALUE_MASK;
    radix = (item.action == RADIX_HEX) ? 64'd16 : 64'd10;
    group = (item.action == RADIX_HEX) ? 4 : 3;
    n = 0;
    if (num == 64'd0) begin
      ch.char_out = CHAR_ZERO;
      ch.last = 1'b1;
      expected_text.push_back(ch);
      return;
    end
    while (num != 64'd0 && n < 20) begin
      digs[n] = 4'(num % radix);
      num = num / radix;
      n++;
    end
    for (p = n - 1; p >= 0; p--) begin
      ch.char_out = (digs[p] < 4'd10) ? CHAR_ZERO + 8'(digs[p]) :
                                        CHAR_A + 8'(digs[p] - 4'd10);
      ch.last = (p == 0);
      expected_text.push_back(ch);
      // A comma follows every full group counted from the right.
      if (p > 0 && p % group == 0) begin
        ch.char_out = CHAR_COMMA;
        ch.last = 1'b0;
        expected_text.push_back(ch);
      end
    end
  endfunction

  function automatic void add_number(bit [63:0] num, bit hex, bit drain);
    number_job_t job;
    job.beat.value = num;
    job.beat.action = hex ? RADIX_HEX : RADIX_DEC;
    job.drain_first = drain;
    pending_numbers.push_back(job);
  endfunction

  // Sender: bursts of beats with random gaps; some numbers wait for an empty pipe.
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_numbers.size() != 0 &&
                   !(pending_numbers[0].drain_first && expected_text.size() != 0)) begin
        in_data <= pending_numbers[0].beat;
        in_valid <= 1'b1;
        pending_numbers.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: alternating stall and free runs, plus one long hold-off.
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  run_left = 0;
  bit  stalling = 1'b1;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && chars_seen >= HOLD_AFTER_CHARS) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        stalling = !stalling;
        if (stalling) begin
          run_left = $urandom_range(1, 6);
        end else begin
          run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) :
                                                    $urandom_range(1, 10);
        end
      end
      run_left--;
      out_stall <= stalling;
    end
  end

  // Monitor: record accepted numbers and check every character beat.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_text(in_data);
      end
      if (out_valid && !out_stall) begin
        chars_seen++;
        if (expected_text.size() == 0) begin
          flag_error($sformatf("unexpected beat char=%h last=%b",
                               out_data.char_out, out_data.last));
        end else begin
          want = expected_text.pop_front();
          if (out_data.char_out !== want.char_out) begin
            flag_error($sformatf("char %h, wanted %h", out_data.char_out, want.char_out));
          end
          if (out_data.last !== want.last) begin
            flag_error($sformatf("last %b, wanted %b on char %h",
                                 out_data.last, want.last, want.char_out));
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    bit [63:0] num;
    bit        hex;
    int        pick;
    int        width;
    int        idx;

    // Directed numbers: zero, extremes, and group and digit-count boundaries.
    add_number(64'd0, 1'b0, 1'b0);
    add_number(64'd0, 1'b1, 1'b0);
    add_number('1, 1'b0, 1'b0);
    add_number('1, 1'b1, 1'b0);
    add_number(64'd1, 1'b0, 1'b0);
    add_number(64'd1, 1'b1, 1'b0);
    add_number(64'd9, 1'b0, 1'b0);
    add_number(64'd10, 1'b0, 1'b0);
    add_number(64'd999, 1'b0, 1'b0);
    add_number(64'd1000, 1'b0, 1'b0);
    add_number(64'd999999, 1'b0, 1'b0);
    add_number(64'd1000000, 1'b0, 1'b0);
    add_number(64'd12345678, 1'b0, 1'b0);
    add_number(64'hF, 1'b1, 1'b0);
    add_number(64'h10, 1'b1, 1'b0);
    add_number(64'hFFFF, 1'b1, 1'b0);
    add_number(64'h10000, 1'b1, 1'b0);
    add_number(64'd9999999999999999999, 1'b0, 1'b0);
    add_number(64'd10000000000000000000, 1'b0, 1'b0);
    add_number(64'h8000_0000_0000_0000, 1'b0, 1'b0);
    add_number(64'h8000_0000_0000_0000, 1'b1, 1'b0);
    add_number(64'h0123_4567_89AB_CDEF, 1'b1, 1'b0);
    add_number(64'hFEDC_BA98_7654_3210, 1'b1, 1'b1);

    // Random numbers, mostly of random magnitude, some at radix-power edges.
    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      hex = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      num = {$urandom, $urandom};
      if (pick < 5) begin
        width = $urandom_range(1, 64);
        num = num >> (64 - width);
      end else if (pick < 7) begin
        num = 64'($urandom_range(0, 2000));
      end else if (pick < 9) begin
        num = 64'd1;
        repeat (hex ? $urandom_range(1, 15) : $urandom_range(1, 19)) begin
          num = num * (hex ? 64'd16 : 64'd10);
        end
        num = num - 64'($urandom_range(0, 1));
      end
      add_number(num, hex, idx == 150);
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Wait for every number to be taken and every character to arrive.
    do @(posedge clk);
    while (pending_numbers.size() != 0 || in_valid || expected_text.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_text.size() != 0) begin
      flag_error($sformatf("%0d characters never arrived", expected_text.size()));
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
